>>> hdl/tbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared widths, register indexes and reset values for the token bucket shaper.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WAIT_BITS_DEF = 32;

    localparam int CAP_W      = 24;
    localparam int RATE_W     = 24;
    localparam int OVH_W      = 8;
    localparam int ELAP_W     = 32;
    localparam int PKT_W      = 16;
    localparam int WAIT_OUT_W = 32;
    localparam int TOKENS_W   = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD = 2'd2;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 24'd16384;
    localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;
    localparam logic [OVH_W-1:0]  OVH_RESET  = 8'd0;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> hdl/tbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_div
// Restoring divider, one quotient bit per cycle, shared compare/subtract.
// ----------------------------------------------------------------------------
module tbs_div #(
    parameter int DIV_W = 33
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [DIV_W-1:0]                 dividend,
    input  logic [tbs_pkg::RATE_W-1:0]       divisor,
    output logic                             done,
    output logic [DIV_W-1:0]                 quotient,
    output logic [tbs_pkg::RATE_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int RW    = tbs_pkg::RATE_W;

    logic [DIV_W-1:0] quo_reg;
    logic [RW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RW:0]      shifted;
    logic [RW:0]      diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, divisor};
        ge      = (shifted >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[RW-1:0] : shifted[RW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/token_bucket_shaper_top.sv
`timescale 1ns / 1ps
// Path: an input word steps through S_MUL, S_CLAMP and S_DECIDE to S_DONE and the output
// register when admitted, oversize or rate zero; a divided wait adds S_DIV and S_FIN.
// Flow: one word at a time, as s_tready is high only in S_IDLE; the bit-serial divider
// (17 + FRAC_BITS steps) sets the wait path, refill takes one 32x24 multiply.
// Reset: asynchronous, active low; registers return to 16384 / 65536 / 0 and the
// bucket starts full with zero fraction.
// ----------------------------------------------------------------------------
// token_bucket_shaper_top
// Token bucket shaper: refill, flag oversize, admit or compute wait ticks, keep fraction.
// ----------------------------------------------------------------------------
module token_bucket_shaper_top #(
    parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF,
    parameter int WAIT_BITS = tbs_pkg::WAIT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // elapsed_ticks[31:0], pkt_bytes[47:32]

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // wait_ticks[31:0], tokens_left[55:32]
    output logic [1:0]                          m_tuser    // admitted_now[0], oversize[1]
);

    localparam int CAP_W   = tbs_pkg::CAP_W;
    localparam int RATE_W  = tbs_pkg::RATE_W;
    localparam int ELAP_W  = tbs_pkg::ELAP_W;
    localparam int PKT_W   = tbs_pkg::PKT_W;
    localparam int WOUT_W  = tbs_pkg::WAIT_OUT_W;
    localparam int LVL_W   = CAP_W + FRAC_BITS;
    localparam int PROD_W  = ELAP_W + RATE_W;
    localparam int SUM_W   = tbs_pkg::max2(PROD_W, LVL_W) + 1;
    localparam int BYTES_W = PKT_W + 1;
    localparam int NEED_W  = BYTES_W + FRAC_BITS;
    localparam int CMP_W   = tbs_pkg::max2(NEED_W, LVL_W);
    localparam int QW      = NEED_W + 1;
    localparam int EW      = tbs_pkg::max2(tbs_pkg::max2(QW, WAIT_BITS), WOUT_W);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_CLAMP  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0]         cap_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic [tbs_pkg::OVH_W-1:0] ovh_reg;
    logic [LVL_W-1:0]         level_reg, level_next;

    logic [ELAP_W-1:0]        elap_reg;
    logic [BYTES_W-1:0]       bytes_reg;
    logic [PROD_W-1:0]        prod_reg;

    logic                     res_admit_reg, res_admit_next;
    logic                     res_over_reg, res_over_next;
    logic [WOUT_W-1:0]        res_wait_reg, res_wait_next;

    logic                     out_valid_reg;
    logic                     out_admit_reg;
    logic                     out_over_reg;
    logic [WOUT_W-1:0]        out_wait_reg;
    logic [tbs_pkg::TOKENS_W-1:0] out_tokens_reg;

    logic [LVL_W-1:0]         cap_fx;
    logic [SUM_W-1:0]         sum;
    logic [NEED_W-1:0]        need;
    logic [NEED_W-1:0]        deficit;
    logic                     over;
    logic                     fits;
    logic                     div_start;
    logic                     div_done;
    logic [NEED_W-1:0]        div_quo;
    logic [RATE_W-1:0]        div_rem;
    logic [QW-1:0]            wait_q;
    logic [EW-1:0]            wait_ext;
    logic [EW-1:0]            wait_max;
    logic                     sat;
    logic [LVL_W-1:0]         resid;
    logic                     out_free;

    tbs_div #(
        .DIV_W (NEED_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (deficit),
        .divisor   (rate_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= tbs_pkg::CAP_RESET;
            rate_reg <= tbs_pkg::RATE_RESET;
            ovh_reg  <= tbs_pkg::OVH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tbs_pkg::REG_CAPACITY: cap_reg  <= cfg_data[CAP_W-1:0];
                tbs_pkg::REG_RATE:     rate_reg <= cfg_data[RATE_W-1:0];
                tbs_pkg::REG_OVERHEAD: ovh_reg  <= cfg_data[tbs_pkg::OVH_W-1:0];
                default:               ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cap_fx   = LVL_W'(cap_reg) << FRAC_BITS;
        sum      = SUM_W'(level_reg) + SUM_W'(prod_reg);
        need     = NEED_W'(bytes_reg) << FRAC_BITS;
        over     = (CAP_W'(bytes_reg) > cap_reg);
        fits     = (CMP_W'(need) <= CMP_W'(level_reg));
        deficit  = need - level_reg[NEED_W-1:0];
        wait_q   = QW'(div_quo) + QW'(div_rem != '0);
        wait_ext = EW'(wait_q);
        wait_max = (EW'(1) << WAIT_BITS) - EW'(1);
        sat      = ((wait_ext >> WAIT_BITS) != '0);
        resid    = (div_rem != '0) ? (LVL_W'(rate_reg) - LVL_W'(div_rem)) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        res_admit_next = res_admit_reg;
        res_over_next  = res_over_reg;
        res_wait_next  = res_wait_reg;
        div_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                level_next = (sum > SUM_W'(cap_fx)) ? cap_fx : sum[LVL_W-1:0];
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_admit_next = 1'b0;
                res_over_next  = 1'b0;
                res_wait_next  = '0;
                if (over)
                begin
                    res_over_next = 1'b1;
                    state_next    = S_DONE;
                end
                else if (fits)
                begin
                    res_admit_next = 1'b1;
                    level_next     = level_reg - LVL_W'(need);
                    state_next     = S_DONE;
                end
                else if (rate_reg == '0)
                begin
                    res_wait_next = wait_max[WOUT_W-1:0];
                    level_next    = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sat)
                begin
                    res_wait_next = wait_max[WOUT_W-1:0];
                    level_next    = '0;
                end
                else
                begin
                    res_wait_next = wait_ext[WOUT_W-1:0];
                    level_next    = (resid > cap_fx) ? cap_fx : resid;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= LVL_W'(tbs_pkg::CAP_RESET) << FRAC_BITS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_admit_reg <= res_admit_next;
        res_over_reg  <= res_over_next;
        res_wait_reg  <= res_wait_next;
        if (state_reg == S_IDLE && s_tvalid)
        begin
            elap_reg  <= s_tdata[ELAP_W-1:0];
            bytes_reg <= BYTES_W'(s_tdata[ELAP_W +: PKT_W]) + BYTES_W'(ovh_reg);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(elap_reg) * PROD_W'(rate_reg);
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_admit_reg  <= res_admit_reg;
            out_over_reg   <= res_over_reg;
            out_wait_reg   <= res_wait_reg;
            out_tokens_reg <= level_reg[LVL_W-1:FRAC_BITS];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tokens_reg, out_wait_reg};
    assign m_tuser  = {out_over_reg, out_admit_reg};

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("admitted and oversize both set");

    a_no_wait_when_passed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> (m_tdata[WOUT_W-1:0] == '0))
        else $error("nonzero wait on admitted or oversize word");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_div_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV) && !div_start)
        else $error("divider start not followed by divide state");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for token_bucket_shaper_top. An internal bucket
// predictor tracks the fixed-point token level and register settings and
// computes the verdict of every accepted packet word. Directed packets hit
// the field extremes, zero rate, zero capacity, wait saturation and a lowered
// capacity. Random traffic then runs under many register settings; both stream
// sides stall at random in the first two runs and not at all in the last.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          FRAC       = tbs_pkg::FRAC_BITS_DEF;
    localparam logic [63:0] WAIT_MAX   = (64'd1 << tbs_pkg::WAIT_BITS_DEF) - 64'd1;
    localparam int          IDLE_LIMIT = 4000;

    typedef struct packed {
        logic                               admitted;
        logic [tbs_pkg::WAIT_OUT_W-1:0]     hold_ticks;
        logic                               oversize;
        logic [tbs_pkg::TOKENS_W-1:0]       tokens_left;
    } shaper_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [47:0]                     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [55:0]                     m_tdata;
    logic [1:0]                      m_tuser;

    // bucket predictor state
    logic [tbs_pkg::CAP_W-1:0]       cap_q = tbs_pkg::CAP_RESET;
    logic [tbs_pkg::RATE_W-1:0]      rate_q = tbs_pkg::RATE_RESET;
    logic [tbs_pkg::OVH_W-1:0]       ovh_q = tbs_pkg::OVH_RESET;
    logic [63:0]                     bucket_fx = 64'(tbs_pkg::CAP_RESET) << FRAC;

    shaper_result_t         shaping_verdicts[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int n_admit = 0;
    int n_wait = 0;
    int n_sat = 0;
    int n_over = 0;
    int n_settings = 0;

    token_bucket_shaper_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic shaper_result_t shape_packet(input logic [31:0] elapsed,
                                                    input logic [15:0] pkt);
        logic [63:0]    lvl;
        logic [63:0]    cap_fx;
        logic [63:0]    bytes;
        logic [63:0]    need;
        logic [63:0]    deficit;
        logic [63:0]    hold;
        logic           sat;
        shaper_result_t r;
        r      = '0;
        bytes  = 64'(pkt) + 64'(ovh_q);
        cap_fx = 64'(cap_q) << FRAC;
        need   = bytes << FRAC;
        lvl    = bucket_fx + 64'(elapsed) * 64'(rate_q);
        if (lvl > cap_fx)
            lvl = cap_fx;
        if (bytes > 64'(cap_q))
        begin
            r.oversize = 1'b1;
            n_over++;
        end
        else if (need <= lvl)
        begin
            r.admitted = 1'b1;
            lvl = lvl - need;
            n_admit++;
        end
        else
        begin
            deficit = need - lvl;
            sat  = 1'b0;
            hold = '0;
            if (rate_q == '0)
                sat = 1'b1;
            else
            begin
                hold = deficit / 64'(rate_q);
                if (hold * 64'(rate_q) != deficit)
                    hold = hold + 64'd1;
                if (hold > WAIT_MAX)
                    sat = 1'b1;
            end
            if (sat)
            begin
                hold = WAIT_MAX;
                lvl  = '0;
                n_sat++;
            end
            else
            begin
                lvl = lvl + hold * 64'(rate_q) - need;
                if (lvl > cap_fx)
                    lvl = cap_fx;
            end
            r.hold_ticks = hold[tbs_pkg::WAIT_OUT_W-1:0];
            n_wait++;
        end
        bucket_fx     = lvl;
        r.tokens_left = lvl[FRAC +: tbs_pkg::TOKENS_W];
        return r;
    endfunction

    task automatic send_packet(input logic [31:0] elapsed, input logic [15:0] pkt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pkt, elapsed};
        do
            @(posedge clk);
        while (!s_tready);
        shaping_verdicts.push_back(shape_packet(elapsed, pkt));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (shaping_verdicts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // block is drained first; every register is written each time
    task automatic set_config(input logic [23:0] cap, input logic [23:0] rate,
                              input logic [7:0] ovh);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= tbs_pkg::REG_CAPACITY;
        cfg_data <= cap;
        @(posedge clk);
        cap_q    = cap;
        cfg_idx  <= tbs_pkg::REG_RATE;
        cfg_data <= rate;
        @(posedge clk);
        rate_q   = rate;
        cfg_idx  <= tbs_pkg::REG_OVERHEAD;
        cfg_data <= {16'd0, ovh};
        @(posedge clk);
        ovh_q    = ovh;
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    task automatic test_directed_extremes();
        // reset settings: 16384 tokens, one token per tick
        send_packet(32'd0, 16'd0);
        send_packet(32'd0, 16'd16384);
        send_packet(32'd0, 16'd1);
        send_packet(32'hFFFF_FFFF, 16'd16385);
        send_packet(32'hFFFF_FFFF, 16'hFFFF);
        // slowest rate, largest bucket, largest overhead: second packet saturates
        set_config(24'hFF_FFFF, 24'd1, 8'hFF);
        send_packet(32'd0, 16'hFFFF);
        send_packet(32'd0, 16'hFFFF);
        send_packet(32'hFFFF_FFFF, 16'd0);
        set_config(24'hFF_FFFF, 24'hFF_FFFF, 8'd0);
        send_packet(32'hFFFF_FFFF, 16'hFFFF);
        send_packet(32'd0, 16'hFFFF);
        send_packet(32'd1, 16'hFFFF);
        // zero rate
        set_config(24'd1000, 24'd0, 8'd0);
        send_packet(32'd0, 16'd1000);
        send_packet(32'hFFFF_FFFF, 16'd1);
        send_packet(32'd5, 16'd1001);
        // zero capacity
        set_config(24'd0, 24'd65536, 8'd0);
        send_packet(32'd10, 16'd0);
        send_packet(32'd10, 16'd1);
        set_config(24'd0, 24'd65536, 8'd7);
        send_packet(32'd0, 16'd0);
        // capacity lowered under a full bucket
        set_config(24'd50000, 24'd65536, 8'd0);
        send_packet(32'hFFFF_FFFF, 16'd0);
        set_config(24'd100, 24'd65536, 8'd0);
        send_packet(32'd0, 16'd0);
        send_packet(32'd0, 16'd100);
        send_packet(32'd0, 16'd101);
        // fractional rate, wait rounds up and fraction is carried
        set_config(24'd1000, 24'h00_AAAB, 8'd3);
        send_packet(32'd3, 16'd0);
        send_packet(32'd1, 16'd1);
        send_packet(32'd7, 16'd2);
    endtask

    task automatic test_random_traffic(input int n_items, input int n_segments);
        logic [23:0] cap;
        logic [23:0] rate;
        logic [7:0]  ovh;
        logic [31:0] elapsed;
        logic [15:0] pkt;
        int          per_seg;
        int          near;
        per_seg = n_items / n_segments;
        for (int seg = 0; seg < n_segments; seg++)
        begin
            case ($urandom_range(9)) inside
                [0:1]:   cap = 24'($urandom_range(2048, 1));
                [2:3]:   cap = 24'($urandom_range(20000, 1500));
                [4:5]:   cap = 24'($urandom_range(24'hFF_FFFF, 1));
                6:       cap = 24'd1;
                7:       cap = 24'hFF_FFFF;
                default: cap = 24'($urandom_range(65800, 65000));
            endcase
            case ($urandom_range(9)) inside
                [0:2]:   rate = 24'($urandom_range(131072, 32768));
                [3:4]:   rate = 24'($urandom_range(255, 1));
                [5:6]:   rate = 24'($urandom_range(24'hFF_FFFF, 1));
                7:       rate = 24'd1;
                8:       rate = 24'hFF_FFFF;
                default: rate = 24'($urandom_range(32768, 4096));
            endcase
            case ($urandom_range(9)) inside
                [0:3]:   ovh = 8'd0;
                [4:7]:   ovh = 8'($urandom_range(255));
                8:       ovh = 8'hFF;
                default: ovh = 8'($urandom_range(40));
            endcase
            set_config(cap, rate, ovh);
            for (int k = 0; k < per_seg; k++)
            begin
                // hold off until the shaper has answered everything
                if (seg == 0 && k == per_seg / 2)
                    drain_results();
                case ($urandom_range(19)) inside
                    0:       elapsed = 32'd0;
                    1:       elapsed = 32'hFFFF_FFFF;
                    2:       elapsed = 32'($urandom_range(16));
                    [3:4]:   elapsed = $urandom();
                    [5:7]:   elapsed = 32'($urandom_range(65535));
                    default: elapsed = 32'($urandom_range(2048));
                endcase
                case ($urandom_range(19)) inside
                    0:       pkt = 16'd0;
                    1:       pkt = 16'hFFFF;
                    [2:3]:   pkt = 16'($urandom_range(63));
                    [4:6]:   pkt = 16'($urandom());
                    7:
                    begin
                        near = int'(cap_q) - int'(ovh_q) + int'($urandom_range(4)) - 2;
                        if (near < 0)
                            near = 0;
                        if (near > 65535)
                            near = 65535;
                        pkt = 16'(near);
                    end
                    default: pkt = 16'($urandom_range(1518, 40));
                endcase
                send_packet(elapsed, pkt);
            end
        end
    endtask

    // result word checker and receiver stalls
    always @(posedge clk)
    begin
        shaper_result_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (shaping_verdicts.size() == 0)
                begin
                    $error("unexpected result word: tdata %h tuser %b", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    exp_r = shaping_verdicts.pop_front();
                    if (m_tuser[0] !== exp_r.admitted)
                    begin
                        $error("admitted_now: expected %0d, got %0d", exp_r.admitted, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata[31:0] !== exp_r.hold_ticks)
                    begin
                        $error("wait_ticks: expected %0d, got %0d",
                               exp_r.hold_ticks, m_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== exp_r.oversize)
                    begin
                        $error("oversize: expected %0d, got %0d", exp_r.oversize, m_tuser[1]);
                        mismatches++;
                    end
                    if (m_tdata[55:32] !== exp_r.tokens_left)
                    begin
                        $error("tokens_left: expected %0d, got %0d",
                               exp_r.tokens_left, m_tdata[55:32]);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on stalled handshakes
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 7;
        recv_idle_pct = 70;
        test_directed_extremes();
        test_random_traffic(430, 6);
        send_idle_pct = 70;
        recv_idle_pct = 7;
        test_random_traffic(430, 6);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(440, 6);
        drain_results();
        repeat (60) @(posedge clk);
        if (shaping_verdicts.size() != 0)
        begin
            $error("%0d result words never arrived", shaping_verdicts.size());
            mismatches++;
        end
        $display("covered %0d register settings: %0d admitted, %0d held (%0d saturated),",
                 n_settings, n_admit, n_wait, n_sat);
        $display("%0d oversize; mismatches: %0d", n_over, mismatches);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
